FILE: rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared definitions for the sorted sequence merger
// Widths, operation codes, sequencer states and the head status struct.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE         = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_HOLD
  } state_t;

  // Which of the two sequences still has entries left to emit.
  typedef struct packed {
    logic first;
    logic second;
  } avail_t;

endpackage

FILE: rtl/ssm_buffer.sv
// ----------------------------------------------------------------------------
// ssm_buffer: storage for one sequence
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssm_buffer (
  input  logic                                clk,
  input  logic                                we,
  input  logic        [ssm_pkg::ADDR_W-1:0]   waddr,
  input  logic signed [ssm_pkg::DATA_W-1:0]   wdata,
  input  logic        [ssm_pkg::ADDR_W-1:0]   raddr,
  output logic signed [ssm_pkg::DATA_W-1:0]   rdata
);
  import ssm_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ssm_cmp.sv
// ----------------------------------------------------------------------------
// ssm_cmp: head selection unit
// Signed compare of the two heads, falling back to whichever side remains.
// ----------------------------------------------------------------------------
module ssm_cmp (
  input  logic signed [ssm_pkg::DATA_W-1:0] head_first,
  input  logic signed [ssm_pkg::DATA_W-1:0] head_second,
  input  ssm_pkg::avail_t                   avail,
  output logic                              take_first
);
  import ssm_pkg::*;

  // Equal heads favor the first sequence.
  always_comb begin
    if (avail.first && avail.second) begin
      take_first = (head_first <= head_second);
    end else begin
      take_first = avail.first;
    end
  end

endmodule

FILE: rtl/sorted_sequence_merger_unit.sv
// ----------------------------------------------------------------------------
// sorted_sequence_merger_unit: two-way merge of two sorted sequences
// Append beats store a value unless full; a merge beat emits all stored values.
// ----------------------------------------------------------------------------
// An append beat is written into its buffer when accepted, unless it is full.
// A merge shows its first result after the buffer read state S_READ and the
// select state S_EMIT. Each result is then held in S_HOLD until it is taken,
// while the next head is read; input is not ready during a merge.
// Reset clears both fill counts, the overflow flag and the sequencer; the
// buffer contents are left as they are and are never emitted past the counts.
module sorted_sequence_merger_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic        [ssm_pkg::OP_W-1:0]   op,
  input  logic signed [ssm_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ssm_pkg::DATA_W-1:0] value_res,
  output logic                              source,
  output logic                              last,
  output logic                              overflowed
);
  import ssm_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] cnt_first, cnt_second;
  logic [CNT_W-1:0] idx_first, idx_second;
  logic             ovf;

  logic signed [DATA_W-1:0] rd_first, rd_second;
  logic                     we_first, we_second;
  logic                     full_first, full_second;
  logic                     in_beat, out_beat;
  logic                     merge_start, merge_empty;
  logic                     load_out;
  logic                     take_first;
  logic                     last_calc;
  avail_t                   avail;

  assign in_beat     = in_valid && in_ready;
  assign out_beat    = out_valid && out_ready;
  assign full_first  = (cnt_first == CNT_W'(DEPTH));
  assign full_second = (cnt_second == CNT_W'(DEPTH));
  assign merge_empty = (cnt_first == '0) && (cnt_second == '0);

  assign avail.first  = (idx_first != cnt_first);
  assign avail.second = (idx_second != cnt_second);

  // The buffers are always read at the current merge indices, so the head
  // data is ready in the cycle after an index moves.
  ssm_buffer u_buf_first (
    .clk   (clk),
    .we    (we_first),
    .waddr (cnt_first[ADDR_W-1:0]),
    .wdata (value),
    .raddr (idx_first[ADDR_W-1:0]),
    .rdata (rd_first)
  );

  ssm_buffer u_buf_second (
    .clk   (clk),
    .we    (we_second),
    .waddr (cnt_second[ADDR_W-1:0]),
    .wdata (value),
    .raddr (idx_second[ADDR_W-1:0]),
    .rdata (rd_second)
  );

  ssm_cmp u_cmp (
    .head_first  (rd_first),
    .head_second (rd_second),
    .avail       (avail),
    .take_first  (take_first)
  );

  // The result being selected is the final one when, after advancing the
  // chosen side, both indices sit at their counts.
  always_comb begin
    if (take_first) begin
      last_calc = (idx_first + CNT_W'(1) == cnt_first) && (idx_second == cnt_second);
    end else begin
      last_calc = (idx_first == cnt_first) && (idx_second + CNT_W'(1) == cnt_second);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && op == OP_MERGE && !merge_empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          state_next = last ? S_IDLE : S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    load_out    = 1'b0;
    merge_start = 1'b0;
    we_first    = 1'b0;
    we_second   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        merge_start = in_valid && op == OP_MERGE && !merge_empty;
        we_first    = in_valid && op == OP_APPEND_FIRST && !full_first;
        we_second   = in_valid && op == OP_APPEND_SECOND && !full_second;
      end
      S_READ: begin
      end
      S_EMIT: begin
        load_out = 1'b1;
      end
      S_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill counts, overflow flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_first  <= '0;
      cnt_second <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_beat) begin
        if (op == OP_APPEND_FIRST) begin
          if (full_first) begin
            ovf <= 1'b1;
          end else begin
            cnt_first <= cnt_first + CNT_W'(1);
          end
        end else if (op == OP_APPEND_SECOND) begin
          if (full_second) begin
            ovf <= 1'b1;
          end else begin
            cnt_second <= cnt_second + CNT_W'(1);
          end
        end else if (op == OP_MERGE && merge_empty) begin
          ovf <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_beat) begin
        out_valid <= 1'b0;
        if (last) begin
          cnt_first  <= '0;
          cnt_second <= '0;
          ovf        <= 1'b0;
        end
      end
    end
  end

  // Merge indices and the output beat register.
  always_ff @(posedge clk) begin
    if (merge_start) begin
      idx_first  <= '0;
      idx_second <= '0;
    end else if (load_out) begin
      if (take_first) begin
        idx_first <= idx_first + CNT_W'(1);
      end else begin
        idx_second <= idx_second + CNT_W'(1);
      end
    end
    if (load_out) begin
      value_res  <= take_first ? rd_first : rd_second;
      source     <= !take_first;
      last       <= last_calc;
      overflowed <= ovf;
    end
  end

endmodule
